// ----- hdl/wls_pkg.sv -----
// package for the weighted lottery selector: sizes, codes, entry layout and
// the interface types of the remainder unit
// depends on nothing
package wls_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 16;
   localparam int RND_W    = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int TOTAL_W  = 20;

   // sum of all weights in a full table never overflows this
   localparam int SUM_W = WEIGHT_W + IDX_W;

   localparam int DIV_CNT_W = $clog2(RND_W + 1);

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DRAWN     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OWNER     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd6;

   localparam logic [WEIGHT_W-1:0] MIN_WEIGHT_RESET = 16'd100;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
      logic                owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- hdl/weighted_lottery_selector_core.sv -----
// top level of the weighted lottery selector: sequencer around the entry ram
// depends on wls_pkg, wls_ram, wls_divider
//
//   port group   direction  handshake             carries
//   req_*        in         req_valid/req_ready   mode, entry id, weight, owner, random
//   rsp_*        out        rsp_valid/rsp_ready   status, slot, winner id, total
//   csr_*        in         csr_write_enable      min_weight, written at once
//
// add and unused modes: the result goes through the holding stage into the rsp register
// remove: one ram read per cycle through the scan
// select: two scans of the ram (sum, then pick)
//   around a remainder unit, one bit per cycle
// reset clears entry count, last winner and min_weight (to 100); the ram
//   keeps its contents, only slots below the count are ever read
// a result waiting in the rsp register does not stop the next transaction;
//   the following result waits in a holding stage until the rsp side frees
module weighted_lottery_selector_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wls_pkg::MODE_W-1:0]    req_mode,
   input  logic [wls_pkg::ID_W-1:0]      req_entry_id,
   input  logic [wls_pkg::WEIGHT_W-1:0]  req_entry_weight,
   input  logic                          req_entry_is_owner,
   input  logic [wls_pkg::RND_W-1:0]     req_random_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wls_pkg::STATUS_W-1:0]  rsp_status,
   output logic [wls_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [wls_pkg::ID_W-1:0]      rsp_winner_id,
   output logic [wls_pkg::TOTAL_W-1:0]   rsp_total_weight,
   input  logic                          csr_write_enable,
   input  logic [wls_pkg::WEIGHT_W-1:0]  csr_write_data
);

   import wls_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RM_SCAN,
      S_RM_LAST,
      S_RM_WRITE,
      S_SUM,
      S_DIV,
      S_PICK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   // table bookkeeping and configuration
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ID_W-1:0]     lw_id_ff, lw_id_in;
   logic                lw_valid_ff, lw_valid_in;
   logic [WEIGHT_W-1:0] min_weight_ff, min_weight_in;

   // latched transaction
   logic [ID_W-1:0]  key_id_ff, key_id_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;

   // scan pipeline: issue address, data comes back in the next cycle
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic [IDX_W-1:0] hit_slot_ff, hit_slot_in;

   // draw arithmetic
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] lo_ff, lo_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic             own_found_ff, own_found_in;
   logic [IDX_W-1:0] own_slot_ff, own_slot_in;
   logic [ID_W-1:0]  own_id_ff, own_id_in;

   // holding stage for a finished result
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [ID_W-1:0]     res_winner_ff, res_winner_in;
   logic [TOTAL_W-1:0]  res_total_ff, res_total_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]     rsp_winner_ff, rsp_winner_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   // ram ports
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_bits;
   entry_type        rd_entry;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic             req_fire;
   logic             issue;
   logic             scanning;
   logic             rd_elig;
   logic [CNT_W-1:0] last_cnt;
   logic [SUM_W:0]   range_end;

   wls_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   wls_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rd_entry  = entry_type'(ram_rd_bits);
   assign last_cnt  = count_ff - CNT_W'(1);

   // scan states walk the slots below the count
   assign scanning = (state_ff == S_RM_SCAN) || (state_ff == S_SUM) || (state_ff == S_PICK);
   assign issue    = scanning && (idx_ff < count_ff);

   // weight at least the threshold and not the previous winner
   assign rd_elig = (rd_entry.weight >= min_weight_ff) &&
                    !(lw_valid_ff && (rd_entry.id == lw_id_ff));

   assign range_end = {1'b0, lo_ff} + (SUM_W+1)'(rd_entry.weight);

   // the last entry is read in S_RM_LAST and written to the hit slot next cycle
   assign ram_rd_addr = (state_ff == S_RM_LAST) ? last_cnt[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lw_id_in      = lw_id_ff;
      lw_valid_in   = lw_valid_ff;
      min_weight_in = min_weight_ff;
      key_id_in     = key_id_ff;
      rnd_in        = rnd_ff;
      idx_in        = idx_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = idx_ff[IDX_W-1:0];
      hit_slot_in   = hit_slot_ff;
      sum_in        = sum_ff;
      lo_in         = lo_ff;
      rem_in        = rem_ff;
      own_found_in  = own_found_ff;
      own_slot_in   = own_slot_ff;
      own_id_in     = own_id_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_winner_in = res_winner_ff;
      res_total_in  = res_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_winner_in = rsp_winner_ff;
      rsp_total_in  = rsp_total_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = '{id: req_entry_id, weight: req_entry_weight, owner: req_entry_is_owner};

      div_req.start    = 1'b0;
      div_req.dividend = rnd_ff;
      div_req.divisor  = sum_ff;

      if (csr_write_enable) begin
         min_weight_in = csr_write_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (issue) begin
         idx_in      = idx_ff + CNT_W'(1);
         pipe_vld_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_slot_in   = '0;
               res_winner_in = '0;
               res_total_in  = '0;
               idx_in        = '0;
               case (req_mode)
                  MODE_ADD: begin
                     if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // write straight from the request
                        ram_wr_en     = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        res_status_in = ST_ADDED;
                        res_slot_in   = SLOT_W'(count_ff);
                     end
                     state_in = S_RESP;
                  end
                  MODE_REMOVE: begin
                     key_id_in = req_entry_id;
                     state_in  = S_RM_SCAN;
                  end
                  MODE_SELECT: begin
                     rnd_in       = req_random_value;
                     sum_in       = '0;
                     own_found_in = 1'b0;
                     state_in     = S_SUM;
                  end
                  default: begin
                     res_status_in = ST_NONE;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         S_RM_SCAN: begin
            if (pipe_vld_ff && (rd_entry.id == key_id_ff)) begin
               hit_slot_in = pipe_idx_ff;
               pipe_vld_in = 1'b0;
               state_in    = S_RM_LAST;
            end else if (!issue && !pipe_vld_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_RESP;
            end
         end

         S_RM_LAST: begin
            state_in = S_RM_WRITE;
         end

         S_RM_WRITE: begin
            // last entry moves into the hole (itself when the hit was last)
            ram_wr_en     = 1'b1;
            ram_wr_addr   = hit_slot_ff;
            ram_wr_data   = rd_entry;
            count_in      = last_cnt;
            res_status_in = ST_REMOVED;
            res_slot_in   = SLOT_W'(hit_slot_ff);
            state_in      = S_RESP;
         end

         S_SUM: begin
            if (pipe_vld_ff) begin
               if (rd_elig) begin
                  sum_in = sum_ff + SUM_W'(rd_entry.weight);
               end
               if (rd_entry.owner && !own_found_ff) begin
                  own_found_in = 1'b1;
                  own_slot_in  = pipe_idx_ff;
                  own_id_in    = rd_entry.id;
               end
            end else if (!issue) begin
               if (sum_ff != '0) begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end else begin
                  // nothing to draw from: first owner entry, if any
                  if (own_found_ff) begin
                     res_status_in = ST_OWNER;
                     res_slot_in   = SLOT_W'(own_slot_ff);
                     res_winner_in = own_id_ff;
                     lw_id_in      = own_id_ff;
                     lw_valid_in   = 1'b1;
                  end else begin
                     res_status_in = ST_NONE;
                  end
                  state_in = S_RESP;
               end
            end
         end

         S_DIV: begin
            if (div_rsp.done) begin
               rem_in   = div_rsp.remainder;
               lo_in    = '0;
               idx_in   = '0;
               state_in = S_PICK;
            end
         end

         S_PICK: begin
            if (pipe_vld_ff && rd_elig) begin
               if ({1'b0, rem_ff} < range_end) begin
                  res_status_in = ST_DRAWN;
                  res_slot_in   = SLOT_W'(pipe_idx_ff);
                  res_winner_in = rd_entry.id;
                  res_total_in  = TOTAL_W'(sum_ff);
                  lw_id_in      = rd_entry.id;
                  lw_valid_in   = 1'b1;
                  pipe_vld_in   = 1'b0;
                  state_in      = S_RESP;
               end else begin
                  lo_in = range_end[SUM_W-1:0];
               end
            end else if (!issue && !pipe_vld_ff) begin
               // cannot happen while the remainder is below the total
               res_status_in = ST_NONE;
               res_total_in  = TOTAL_W'(sum_ff);
               state_in      = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_winner_in = res_winner_ff;
               rsp_total_in  = res_total_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         lw_id_ff      <= '0;
         lw_valid_ff   <= 1'b0;
         min_weight_ff <= MIN_WEIGHT_RESET;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         lw_id_ff      <= lw_id_in;
         lw_valid_ff   <= lw_valid_in;
         min_weight_ff <= min_weight_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_id_ff     <= key_id_in;
      rnd_ff        <= rnd_in;
      idx_ff        <= idx_in;
      pipe_idx_ff   <= pipe_idx_in;
      hit_slot_ff   <= hit_slot_in;
      sum_ff        <= sum_in;
      lo_ff         <= lo_in;
      rem_ff        <= rem_in;
      own_found_ff  <= own_found_in;
      own_slot_ff   <= own_slot_in;
      own_id_ff     <= own_id_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_winner_ff <= res_winner_in;
      res_total_ff  <= res_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_winner_id    = rsp_winner_ff;
   assign rsp_total_weight = rsp_total_ff;

endmodule

// ----- hdl/wls_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
module wls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/wls_divider.sv -----
// restoring remainder unit: dividend mod divisor, one quotient bit a cycle
// depends on wls_pkg
module wls_divider (
   input  logic                clock,
   input  logic                reset,
   input  wls_pkg::div_req_type div_req,
   output wls_pkg::div_rsp_type div_rsp
);

   import wls_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0]     quo_ff, quo_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;
   logic [SUM_W:0]       shifted;

   assign shifted = {rem_ff, quo_ff[RND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(RND_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[RND_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = SUM_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[SUM_W-1:0];
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- hdl/wls_checker.sv -----
// port-level checker for the weighted lottery selector, bound to the top level
// depends on wls_pkg and weighted_lottery_selector_core
module wls_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [wls_pkg::STATUS_W-1:0]  rsp_status,
   input logic [wls_pkg::SLOT_W-1:0]    rsp_slot_index,
   input logic [wls_pkg::ID_W-1:0]      rsp_winner_id,
   input logic [wls_pkg::TOTAL_W-1:0]   rsp_total_weight
);

   import wls_pkg::*;

   // transactions taken in but not yet delivered
   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_fire && !rsp_fire) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_index) && $stable(rsp_winner_id) && $stable(rsp_total_weight))
      else $error("result changed while stalled");

   // no result without a transaction behind it
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result with no pending transaction");

   // one in the output register and one in work at most
   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> outstanding_ff <= 2'd1)
      else $error("too many transactions in flight");

   // a draw always has a non-zero total and an add carries no winner
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ST_DRAWN || rsp_total_weight != '0) &&
      (rsp_status != ST_ADDED || (rsp_winner_id == '0 && rsp_total_weight == '0)))
      else $error("result fields inconsistent with status");

endmodule

bind weighted_lottery_selector_core wls_checker u_wls_checker (.*);

// ----- tb/tb_weighted_lottery_selector_core.sv -----
// self-checking testbench for weighted_lottery_selector_core: drives add, remove,
// select and unused transactions and checks every response against a behavioural
// copy of the entry table; depends on wls_pkg and the core rtl
`timescale 1ns / 100ps

module tb_weighted_lottery_selector_core;
   import wls_pkg::*;

   // the one mode the core does not use, answered with a plain none
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned RUN_LIMIT_CYCLES = 400000;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned SETTLE_CYCLES    = 100;
   localparam int unsigned IDLE_PERCENT     = 22;

   // ids 16'h0018 to 16'h00ff are never added, so this one is never in the table
   localparam logic [ID_W-1:0] ABSENT_ID = 16'h00A5;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [ID_W-1:0]     winner_id;
      logic [TOTAL_W-1:0]  total_weight;
   } draw_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode;
   logic [ID_W-1:0]     req_entry_id;
   logic [WEIGHT_W-1:0] req_entry_weight;
   logic                req_entry_is_owner;
   logic [RND_W-1:0]    req_random_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic [ID_W-1:0]     rsp_winner_id;
   logic [TOTAL_W-1:0]  rsp_total_weight;
   logic                csr_write_enable;
   logic [WEIGHT_W-1:0] csr_write_data;

   // responses predicted at acceptance, oldest first
   draw_result_type awaited_results[$];
   int unsigned     mismatch_count;
   int unsigned     cycle_count;

   // idling controls, set by the test sequence
   bit sender_idling;
   bit receiver_idling;
   bit hold_off_request;

   // behavioural copy of the core state
   logic [ID_W-1:0]     shadow_ids     [MAX_ENTRIES];
   logic [WEIGHT_W-1:0] shadow_weights [MAX_ENTRIES];
   logic                shadow_owner   [MAX_ENTRIES];
   int unsigned         shadow_count;
   logic [ID_W-1:0]     shadow_last_winner;
   bit                  shadow_winner_valid;
   logic [WEIGHT_W-1:0] shadow_min_weight;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   weighted_lottery_selector_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_entry_id       (req_entry_id),
      .req_entry_weight   (req_entry_weight),
      .req_entry_is_owner (req_entry_is_owner),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_winner_id      (rsp_winner_id),
      .rsp_total_weight   (rsp_total_weight),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic void clear_shadow();
      shadow_count        = 0;
      shadow_last_winner  = '0;
      shadow_winner_valid = 1'b0;
      shadow_min_weight   = MIN_WEIGHT_RESET;
   endfunction

   // heavy enough, and not the previous winner while one exists
   function automatic bit draw_eligible(int unsigned slot);
      if (shadow_weights[slot] < shadow_min_weight)
         return 1'b0;
      if (shadow_winner_valid && shadow_ids[slot] == shadow_last_winner)
         return 1'b0;
      return 1'b1;
   endfunction

   // works out the response of one transaction and moves the shadow state on
   function automatic draw_result_type lottery_outcome(logic [MODE_W-1:0]   mode,
                                                       logic [ID_W-1:0]     id,
                                                       logic [WEIGHT_W-1:0] weight,
                                                       logic                owner,
                                                       logic [RND_W-1:0]    rnd);
      draw_result_type res;
      int unsigned     i;
      int unsigned     last;
      int unsigned     total;
      int unsigned     pick;
      int unsigned     lo;
      bit              done;

      res.status       = ST_NONE;
      res.slot_index   = '0;
      res.winner_id    = '0;
      res.total_weight = '0;
      done             = 1'b0;

      case (mode)
         MODE_ADD: begin
            if (shadow_count >= MAX_ENTRIES) begin
               res.status = ST_FULL;
            end else begin
               shadow_ids[shadow_count]     = id;
               shadow_weights[shadow_count] = weight;
               shadow_owner[shadow_count]   = owner;
               res.status     = ST_ADDED;
               res.slot_index = shadow_count[SLOT_W-1:0];
               shadow_count++;
            end
         end

         MODE_REMOVE: begin
            // first match wins, the last entry is moved into its slot
            res.status = ST_NOT_FOUND;
            for (i = 0; i < shadow_count && !done; i++) begin
               if (shadow_ids[i] == id) begin
                  last              = shadow_count - 1;
                  shadow_ids[i]     = shadow_ids[last];
                  shadow_weights[i] = shadow_weights[last];
                  shadow_owner[i]   = shadow_owner[last];
                  shadow_count      = last;
                  res.status        = ST_REMOVED;
                  res.slot_index    = i[SLOT_W-1:0];
                  done              = 1'b1;
               end
            end
         end

         MODE_SELECT: begin
            total = 0;
            for (i = 0; i < shadow_count; i++)
               if (draw_eligible(i))
                  total += shadow_weights[i];

            if (total != 0) begin
               // half-open prefix ranges in table order
               pick = rnd % total;
               lo   = 0;
               res.total_weight = total[TOTAL_W-1:0];
               for (i = 0; i < shadow_count && !done; i++) begin
                  if (draw_eligible(i)) begin
                     if (pick >= lo && pick < lo + shadow_weights[i]) begin
                        res.status          = ST_DRAWN;
                        res.slot_index      = i[SLOT_W-1:0];
                        res.winner_id       = shadow_ids[i];
                        shadow_last_winner  = shadow_ids[i];
                        shadow_winner_valid = 1'b1;
                        done                = 1'b1;
                     end else begin
                        lo += shadow_weights[i];
                     end
                  end
               end
            end else begin
               // zero total: first owner entry in table order, if any
               for (i = 0; i < shadow_count && !done; i++) begin
                  if (shadow_owner[i]) begin
                     res.status          = ST_OWNER;
                     res.slot_index      = i[SLOT_W-1:0];
                     res.winner_id       = shadow_ids[i];
                     shadow_last_winner  = shadow_ids[i];
                     shadow_winner_valid = 1'b1;
                     done                = 1'b1;
                  end
               end
            end
         end

         default: begin
            // unused mode: none, no state change
         end
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // mostly a small pool so duplicates and the last-winner rule come up often;
   // the wide ids skip 16'h0018 to 16'h00ff so that a known-absent id exists
   function automatic logic [ID_W-1:0] random_entry_id();
      if ($urandom_range(99) < 75)
         return ID_W'($urandom_range(23));
      return ID_W'($urandom_range(16'hFFFF, 16'h0100));
   endfunction

   // weights cluster around the threshold values used in the run
   function automatic logic [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return WEIGHT_W'($urandom_range(110, 90));
         4, 5:    return WEIGHT_W'($urandom_range(2500));
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   function automatic logic [RND_W-1:0] random_draw_value();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         default: return RND_W'($urandom);
      endcase
   endfunction

   // one transaction on the req side; called at a rising edge, returns at the
   // edge where it was accepted with valid still high, so a following item
   // can go straight on without a gap
   task automatic send_item(input logic [MODE_W-1:0]   mode,
                            input logic [ID_W-1:0]     id,
                            input logic [WEIGHT_W-1:0] weight,
                            input logic                owner,
                            input logic [RND_W-1:0]    rnd);
      while (sender_idling && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_entry_id       <= id;
      req_entry_weight   <= weight;
      req_entry_is_owner <= owner;
      req_random_value   <= rnd;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      awaited_results.push_back(lottery_outcome(mode, id, weight, owner, rnd));
   endtask

   // every response is one transaction, so an empty queue means the core is idle
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_min_weight(input logic [WEIGHT_W-1:0] value);
      wait_for_quiet();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      shadow_min_weight = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // well-formed mix: removes mostly hit a live id, adds ease off as the
   // table fills so both the full and the empty edges are visited
   task automatic run_random_traffic(input int unsigned items);
      int unsigned       n;
      int unsigned       roll;
      int unsigned       add_share;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   id;
      for (n = 0; n < items; n++) begin
         roll      = $urandom_range(99);
         add_share = (shadow_count < 12) ? 40 : 22;
         if (roll < 3)
            mode = MODE_UNUSED;
         else if (shadow_count < 3 || roll < add_share)
            mode = MODE_ADD;
         else if (roll < 62)
            mode = MODE_REMOVE;
         else
            mode = MODE_SELECT;
         id = random_entry_id();
         if (mode == MODE_REMOVE && shadow_count != 0 && $urandom_range(99) < 80)
            id = shadow_ids[$urandom_range(shadow_count - 1)];
         send_item(mode, id, random_weight(), $urandom_range(99) < 25, random_draw_value());
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // nothing in the table: no draw, no owner, nothing to remove
   task automatic test_empty_table();
      send_item(MODE_SELECT, '0, '1, 1'b1, '1);
      send_item(MODE_REMOVE, '1, '0, 1'b0, '0);
      send_item(MODE_UNUSED, '1, '1, 1'b1, '1);
   endtask

   // owner fallback when nothing is eligible, zero weights at threshold 0,
   // the widest weight at the top threshold and the last-winner exclusion
   task automatic test_owner_fallback();
      send_item(MODE_ADD, '0, '0, 1'b1, '0);
      send_item(MODE_SELECT, '1, '1, 1'b0, '0);
      write_min_weight('0);
      send_item(MODE_ADD, 16'h1234, '0, 1'b0, '1);
      send_item(MODE_SELECT, '0, '0, 1'b0, 32'h1234_5678);
      write_min_weight('1);
      send_item(MODE_ADD, '1, '1, 1'b0, '0);
      send_item(MODE_SELECT, '0, '0, 1'b1, '1);
      send_item(MODE_SELECT, '1, '1, 1'b1, '0);
      write_min_weight(MIN_WEIGHT_RESET);
   endtask

   // fill to the top, one add too many, a draw over the full table, then a
   // remove that pulls the last entry down and a remove of an unknown id
   task automatic test_table_full();
      while (shadow_count < MAX_ENTRIES)
         send_item(MODE_ADD, random_entry_id(), random_weight(),
                   $urandom_range(99) < 25, random_draw_value());
      send_item(MODE_ADD, '1, '1, 1'b1, '1);
      send_item(MODE_SELECT, '0, '0, 1'b0, random_draw_value());
      send_item(MODE_REMOVE, '1, '0, 1'b0, '0);
      send_item(MODE_REMOVE, ABSENT_ID, '1, 1'b1, '1);
   endtask

   // the rsp side holds off for a long stretch while the req side keeps
   // offering, so the holding stage fills and req_ready must drop
   task automatic test_output_backpressure();
      wait_for_quiet();
      sender_idling    = 1'b0;
      hold_off_request = 1'b1;
      run_random_traffic(12);
      sender_idling    = 1'b1;
      wait_for_quiet();
   endtask

   // random traffic under several thresholds, one phase without any idling
   task automatic test_random_mixed();
      write_min_weight(MIN_WEIGHT_RESET);
      run_random_traffic(95);
      write_min_weight(WEIGHT_W'($urandom_range(3000)));
      run_random_traffic(95);
      write_min_weight('0);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      run_random_traffic(95);
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      write_min_weight(WEIGHT_W'($urandom));
      run_random_traffic(95);
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      req_valid          <= 1'b0;
      req_mode           <= MODE_ADD;
      req_entry_id       <= '0;
      req_entry_weight   <= '0;
      req_entry_is_owner <= 1'b0;
      req_random_value   <= '0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      reset              <= 1'b1;
      sender_idling    = 1'b1;
      receiver_idling  = 1'b1;
      hold_off_request = 1'b0;
      clear_shadow();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_owner_fallback();
      test_table_full();
      test_output_backpressure();
      test_random_mixed();

      // nothing may turn up after the last awaited response
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS weighted_lottery_selector_core");
      else
         $display("FAIL weighted_lottery_selector_core");
      $finish;
   end

   // rsp side: random stalls, and one long hold-off counted here on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= !(receiver_idling && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: response with none awaited, status %0d slot %0d id %0d total %0d",
                     $time, rsp_status, rsp_slot_index, rsp_winner_id, rsp_total_weight);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("slot_index", 32'(want.slot_index), 32'(rsp_slot_index));
            check_field("winner_id", 32'(want.winner_id), 32'(rsp_winner_id));
            check_field("total_weight", 32'(want.total_weight), 32'(rsp_total_weight));
         end
      end
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL weighted_lottery_selector_core");
      $finish;
   end

endmodule
